[rtl/unix_time_to_calendar_unit_assert.svh]
// ----------------------------------------------------------------------------
// unix_time_to_calendar_unit assertion macros
// shorthand for clocked implication checks with a synchronous reset
// ----------------------------------------------------------------------------
`ifndef UNIX_TIME_TO_CALENDAR_UNIT_ASSERT_SVH
`define UNIX_TIME_TO_CALENDAR_UNIT_ASSERT_SVH

// same-cycle implication
`define UTC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// next-cycle implication
`define UTC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

[rtl/utc_pkg.sv]
// ----------------------------------------------------------------------------
// utc_pkg
// constants and small tables for the unix time to calendar converter
// ----------------------------------------------------------------------------
package utc_pkg;

   localparam int unsigned TIME_W  = 32;
   localparam int unsigned REM_W   = 11;
   localparam int unsigned DAYS_W  = 11;
   localparam int unsigned YOFF_W  = 8;
   localparam int unsigned CNT_W   = 5;
   localparam int unsigned PHASE_W = 2;

   localparam logic [TIME_W-1:0] EPOCH_SHIFT = 32'd946684800;
   localparam logic [11:0]       BASE_YEAR   = 12'd2000;
   localparam logic [3:0]        LAST_MONTH  = 4'd12;
   localparam logic [3:0]        FEBRUARY    = 4'd2;

   // divider phases
   localparam logic [PHASE_W-1:0] PH_SEC  = 2'd0;
   localparam logic [PHASE_W-1:0] PH_MIN  = 2'd1;
   localparam logic [PHASE_W-1:0] PH_HOUR = 2'd2;
   localparam logic [PHASE_W-1:0] PH_QUAD = 2'd3;

   typedef logic [PHASE_W-1:0] phase_type;

   // divisor of each phase: 60, 60, 24 and days in four years
   function automatic logic [REM_W-1:0] div_const(input phase_type ph);
      logic [REM_W-1:0] d;
      unique case (ph)
         PH_SEC:  d = 11'd60;
         PH_MIN:  d = 11'd60;
         PH_HOUR: d = 11'd24;
         PH_QUAD: d = 11'd1461;
         default: d = 11'd60;
      endcase
      return d;
   endfunction

   // dividend bits of each phase, minus one
   function automatic logic [CNT_W-1:0] div_len(input phase_type ph);
      logic [CNT_W-1:0] n;
      unique case (ph)
         PH_SEC:  n = 5'd31;
         PH_MIN:  n = 5'd26;
         PH_HOUR: n = 5'd20;
         PH_QUAD: n = 5'd15;
         default: n = 5'd31;
      endcase
      return n;
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
      logic [4:0] len;
      unique case (mon)
         4'd2:                    len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
         default:                 len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

[rtl/unix_time_to_calendar_unit.sv]
// ----------------------------------------------------------------------------
// unix_time_to_calendar_unit
// converts seconds since 1970 into year, month, day, hour, minute and second
// ----------------------------------------------------------------------------
// One request at a time. The time is rebased to 2000-01-01 (wrapping modulo
// 2^32, so times before 2000 land in 2106..2136), then a bit-serial restoring
// divider with an 11-bit remainder peels off seconds, minutes, hours and
// four-year groups of 1461 days. Up to three single years and up to eleven
// months are then subtracted, one per cycle. Every fourth year is leap, 2100
// included. The next request is taken once the result sits in the output
// register, which holds it for as long as rsp_stall is high.
module unix_time_to_calendar_unit
   import utc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_unix_time,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [11:0] rsp_year,
   output logic [3:0]  rsp_month,
   output logic [4:0]  rsp_day,
   output logic [4:0]  rsp_hour,
   output logic [5:0]  rsp_minute,
   output logic [5:0]  rsp_second
);

`include "unix_time_to_calendar_unit_assert.svh"

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DIV    = 3'd1;
   localparam logic [2:0] ST_YEAR   = 3'd2;
   localparam logic [2:0] ST_MONTH  = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   // control state
   logic [2:0]         state_ff, state_in;
   phase_type          phase_ff, phase_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // datapath
   logic [TIME_W-1:0]  shift_ff, shift_in;   // dividend in, quotient bits out
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [5:0]         sec_ff, sec_in;
   logic [5:0]         min_ff, min_in;
   logic [4:0]         hour_ff, hour_in;
   logic [DAYS_W-1:0]  days_ff, days_in;
   logic [YOFF_W-1:0]  yoff_ff, yoff_in;
   logic [3:0]         mon_ff, mon_in;

   // output register
   logic [11:0]        year_out_ff, year_out_in;
   logic [3:0]         month_out_ff, month_out_in;
   logic [4:0]         day_out_ff, day_out_in;
   logic [4:0]         hour_out_ff, hour_out_in;
   logic [5:0]         min_out_ff, min_out_in;
   logic [5:0]         sec_out_ff, sec_out_in;

   // one divider step
   logic [REM_W-1:0]   divisor;
   logic [REM_W:0]     rem_wide;
   logic [REM_W:0]     rem_diff;
   logic               quot_bit;
   logic [REM_W-1:0]   rem_next;
   logic [TIME_W-1:0]  shift_next;

   // year and month peeling
   logic               leap;
   logic [DAYS_W-1:0]  year_len;
   logic [DAYS_W-1:0]  mon_len;
   logic               out_free;

   assign divisor    = div_const(phase_ff);
   assign rem_wide   = {rem_ff, shift_ff[TIME_W-1]};
   assign rem_diff   = rem_wide - {1'b0, divisor};
   assign quot_bit   = (rem_wide >= {1'b0, divisor});
   assign rem_next   = quot_bit ? rem_diff[REM_W-1:0] : rem_wide[REM_W-1:0];
   assign shift_next = {shift_ff[TIME_W-2:0], quot_bit};

   // leap when the year offset is a multiple of four
   assign leap     = (yoff_ff[1:0] == 2'b00);
   assign year_len = leap ? 11'd366 : 11'd365;
   assign mon_len  = {6'd0, month_len(mon_ff, leap)};

   // output register can take a new result
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      count_in     = count_ff;
      shift_in     = shift_ff;
      rem_in       = rem_ff;
      sec_in       = sec_ff;
      min_in       = min_ff;
      hour_in      = hour_ff;
      days_in      = days_ff;
      yoff_in      = yoff_ff;
      mon_in       = mon_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      year_out_in  = year_out_ff;
      month_out_in = month_out_ff;
      day_out_in   = day_out_ff;
      hour_out_in  = hour_out_ff;
      min_out_in   = min_out_ff;
      sec_out_in   = sec_out_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               // rebase to 2000, wraps for earlier times
               shift_in = req_unix_time - EPOCH_SHIFT;
               rem_in   = '0;
               phase_in = PH_SEC;
               count_in = div_len(PH_SEC);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            shift_in = shift_next;
            rem_in   = rem_next;
            count_in = count_ff - 5'd1;
            if (count_ff == '0) begin
               rem_in   = '0;
               phase_in = phase_ff + 2'd1;
               count_in = div_len(phase_ff + 2'd1);
               // left-align the quotient as the next dividend
               case (phase_ff)
                  PH_SEC: begin
                     sec_in   = rem_next[5:0];
                     shift_in = shift_next << 5;
                  end
                  PH_MIN: begin
                     min_in   = rem_next[5:0];
                     shift_in = shift_next << 11;
                  end
                  PH_HOUR: begin
                     hour_in  = rem_next[4:0];
                     shift_in = shift_next << 16;
                  end
                  default: begin
                     // four-year groups: remainder is days into the group
                     days_in  = rem_next;
                     yoff_in  = {shift_next[5:0], 2'b00};
                     state_in = ST_YEAR;
                  end
               endcase
            end
         end
         ST_YEAR: begin
            if (days_ff < year_len) begin
               mon_in   = 4'd1;
               state_in = ST_MONTH;
            end else begin
               days_in = days_ff - year_len;
               yoff_in = yoff_ff + 8'd1;
            end
         end
         ST_MONTH: begin
            if (days_ff < mon_len || mon_ff == LAST_MONTH) begin
               state_in = ST_FINISH;
            end else begin
               days_in = days_ff - mon_len;
               mon_in  = mon_ff + 4'd1;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               year_out_in  = BASE_YEAR + {4'd0, yoff_ff};
               month_out_in = mon_ff;
               day_out_in   = days_ff[4:0] + 5'd1;
               hour_out_in  = hour_ff;
               min_out_in   = min_ff;
               sec_out_in   = sec_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_SEC;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff     <= shift_in;
      rem_ff       <= rem_in;
      sec_ff       <= sec_in;
      min_ff       <= min_in;
      hour_ff      <= hour_in;
      days_ff      <= days_in;
      yoff_ff      <= yoff_in;
      mon_ff       <= mon_in;
      year_out_ff  <= year_out_in;
      month_out_ff <= month_out_in;
      day_out_ff   <= day_out_in;
      hour_out_ff  <= hour_out_in;
      min_out_ff   <= min_out_in;
      sec_out_ff   <= sec_out_in;
   end

   // a new request waits until the previous one has reached the output register
   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_year   = year_out_ff;
   assign rsp_month  = month_out_ff;
   assign rsp_day    = day_out_ff;
   assign rsp_hour   = hour_out_ff;
   assign rsp_minute = min_out_ff;
   assign rsp_second = sec_out_ff;

   // divider remainder always below the divisor
   `UTC_ASSERT_IMPLY(a_rem_below_div, clock, reset, state_ff == ST_DIV, rem_ff < divisor)
   // leftover days within one four-year group while years are peeled
   `UTC_ASSERT_IMPLY(a_days_in_group, clock, reset, state_ff == ST_YEAR, days_ff < 11'd1461)
   // month counter stays in range while peeling months
   `UTC_ASSERT_IMPLY(a_month_range, clock, reset, state_ff == ST_MONTH,
                     mon_ff >= 4'd1 && mon_ff <= LAST_MONTH)
   // every request is followed by a divider pass
   `UTC_ASSERT_NEXT(a_accept_starts_div, clock, reset, req_valid && !req_stall,
                    state_ff == ST_DIV && phase_ff == PH_SEC)
   // a finished result is well formed
   `UTC_ASSERT_IMPLY(a_result_range, clock, reset, rsp_valid_ff,
                     rsp_day != 5'd0 && rsp_hour < 5'd24 && rsp_minute < 6'd60)

endmodule
